/* design/rtpg_pkg.sv */
package rtpg_pkg;

    localparam int CHAN_W = 8;
    localparam int POS_W  = 11;
    localparam int CFG_W  = 12;
    localparam int STEP_W = 2;
    localparam int IDX_W  = 2;

    localparam int MAX_LINE_PIXELS_DEF = 2048;
    localparam int MAX_LINES_DEF       = 2048;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_MIN = 8'h00;

    localparam logic [CFG_W-1:0]  WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RST = 12'd480;
    localparam logic [STEP_W-1:0] SHIFT_RST  = 2'd3;

    typedef enum logic [2:0] {
        PH_RED_UP     = 3'd0,
        PH_RED_DOWN   = 3'd1,
        PH_GREEN_UP   = 3'd2,
        PH_GREEN_DOWN = 3'd3,
        PH_BLUE_UP    = 3'd4,
        PH_BLUE_DOWN  = 3'd5
    } phase_t;

    typedef enum logic [IDX_W-1:0] {
        CFG_ACTIVE_WIDTH  = 2'd0,
        CFG_ACTIVE_HEIGHT = 2'd1,
        CFG_LINE_SHIFT    = 2'd2,
        CFG_FRAME_SHIFT   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        phase_t            phase;
    } walk_t;

    typedef struct packed {
        logic [CFG_W-1:0]  active_width;
        logic [CFG_W-1:0]  active_height;
        logic [STEP_W-1:0] line_shift_steps;
        logic [STEP_W-1:0] frame_shift_steps;
    } cfg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [POS_W-1:0]  column;
        logic [POS_W-1:0]  row;
        logic              end_of_line;
        logic              end_of_frame;
    } pixel_t;

    localparam walk_t WALK_ZERO = '{
        red: CHAN_MIN, green: CHAN_MIN, blue: CHAN_MIN, phase: PH_BLUE_DOWN
    };

    localparam walk_t FRAME_START = '{
        red: CHAN_MIN, green: CHAN_MAX, blue: CHAN_MAX, phase: PH_BLUE_DOWN
    };

    function automatic walk_t walk_step(walk_t w);
        walk_t r;
        r = w;
        unique case (w.phase)
            PH_RED_UP:
                if (w.red != CHAN_MAX) r.red = w.red + 1'b1;
                else r.phase = PH_GREEN_DOWN;
            PH_GREEN_UP:
                if (w.green != CHAN_MAX) r.green = w.green + 1'b1;
                else r.phase = PH_BLUE_DOWN;
            PH_BLUE_UP:
                if (w.blue != CHAN_MAX) r.blue = w.blue + 1'b1;
                else r.phase = PH_RED_DOWN;
            PH_RED_DOWN:
                if (w.red != CHAN_MIN) r.red = w.red - 1'b1;
                else r.phase = PH_GREEN_UP;
            PH_GREEN_DOWN:
                if (w.green != CHAN_MIN) r.green = w.green - 1'b1;
                else r.phase = PH_BLUE_UP;
            PH_BLUE_DOWN:
                if (w.blue != CHAN_MIN) r.blue = w.blue - 1'b1;
                else r.phase = PH_RED_UP;
            default:
                r = w;
        endcase
        return r;
    endfunction

    function automatic walk_t walk_steps(walk_t w, logic [STEP_W-1:0] n);
        walk_t s1;
        walk_t s2;
        walk_t s3;
        walk_t r;
        s1 = walk_step(w);
        s2 = walk_step(s1);
        s3 = walk_step(s2);
        unique case (n)
            2'd0: r = w;
            2'd1: r = s1;
            2'd2: r = s2;
            default: r = s3;
        endcase
        return r;
    endfunction

endpackage

/* design/rtpg_if.sv */
interface rtpg_cmd_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface rtpg_pix_if;
    logic                           valid;
    logic                           ready;
    logic [rtpg_pkg::CHAN_W-1:0]    red;
    logic [rtpg_pkg::CHAN_W-1:0]    green;
    logic [rtpg_pkg::CHAN_W-1:0]    blue;
    logic [rtpg_pkg::POS_W-1:0]     column;
    logic [rtpg_pkg::POS_W-1:0]     row;
    logic                           end_of_line;
    logic                           end_of_frame;

    modport source (
        output valid, output red, output green, output blue,
        output column, output row, output end_of_line, output end_of_frame,
        input ready
    );
    modport sink (
        input valid, input red, input green, input blue,
        input column, input row, input end_of_line, input end_of_frame,
        output ready
    );
endinterface

/* design/rtpg_cfg.sv */
module rtpg_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rtpg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rtpg_pkg::CFG_W-1:0]   cfg_data,
    output rtpg_pkg::cfg_t               cfg
);
    import rtpg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACTIVE_WIDTH:  cfg_next.active_width = cfg_data;
                CFG_ACTIVE_HEIGHT: cfg_next.active_height = cfg_data;
                CFG_LINE_SHIFT:    cfg_next.line_shift_steps = cfg_data[STEP_W-1:0];
                CFG_FRAME_SHIFT:   cfg_next.frame_shift_steps = cfg_data[STEP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_width      <= WIDTH_RST;
            cfg_reg.active_height     <= HEIGHT_RST;
            cfg_reg.line_shift_steps  <= SHIFT_RST;
            cfg_reg.frame_shift_steps <= SHIFT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/rtpg_gen.sv */
module rtpg_gen #(
    parameter int MAX_LINE_PIXELS = rtpg_pkg::MAX_LINE_PIXELS_DEF,
    parameter int MAX_LINES       = rtpg_pkg::MAX_LINES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rtpg_pkg::cfg_t  cfg,
    input  logic            accept,
    input  logic            restart,
    output rtpg_pkg::pixel_t res
);
    import rtpg_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_PIXELS);
    localparam int ROW_W = $clog2(MAX_LINES);

    walk_t pixel_reg, pixel_next;
    walk_t line_reg, line_next;
    walk_t frame_reg, frame_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    walk_t            frame_cur;
    walk_t            pixel_cur;
    walk_t            line_base;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W:0]   width_eff;
    logic [ROW_W:0]   height_eff;
    logic [CFG_W:0]   col_ext;
    logic [CFG_W:0]   row_ext;
    logic             eol;
    logic             eof;

    // clamp sizes: zero acts as one, oversize saturates
    always_comb
    begin
        if (cfg.active_width == '0)
            width_eff = (COL_W+1)'(1);
        else if ({1'b0, cfg.active_width} > (CFG_W+1)'(MAX_LINE_PIXELS))
            width_eff = (COL_W+1)'(MAX_LINE_PIXELS);
        else
            width_eff = (COL_W+1)'(cfg.active_width);

        if (cfg.active_height == '0)
            height_eff = (ROW_W+1)'(1);
        else if ({1'b0, cfg.active_height} > (CFG_W+1)'(MAX_LINES))
            height_eff = (ROW_W+1)'(MAX_LINES);
        else
            height_eff = (ROW_W+1)'(cfg.active_height);
    end

    always_comb
    begin
        frame_cur = restart ? FRAME_START : frame_reg;
        col_cur   = restart ? '0 : col_reg;
        row_cur   = restart ? '0 : row_reg;

        frame_next = frame_cur;
        line_next  = line_reg;
        pixel_cur  = pixel_reg;
        line_base  = line_reg;

        if (col_cur == '0)
        begin
            if (row_cur == '0)
            begin
                line_base  = frame_cur;
                frame_next = walk_steps(frame_cur, cfg.frame_shift_steps);
            end
            line_next = walk_steps(line_base, cfg.line_shift_steps);
            pixel_cur = line_next;
        end

        pixel_next = walk_step(pixel_cur);

        eol = ({1'b0, col_cur} + 1'b1) >= width_eff;
        eof = eol && (({1'b0, row_cur} + 1'b1) >= height_eff);

        if (eol)
        begin
            col_next = '0;
            row_next = eof ? '0 : row_cur + 1'b1;
        end
        else
        begin
            col_next = col_cur + 1'b1;
            row_next = row_cur;
        end
    end

    always_comb
    begin
        col_ext          = (CFG_W+1)'(col_cur);
        row_ext          = (CFG_W+1)'(row_cur);
        res.red          = pixel_cur.red;
        res.green        = pixel_cur.green;
        res.blue         = pixel_cur.blue;
        res.column       = col_ext[POS_W-1:0];
        res.row          = row_ext[POS_W-1:0];
        res.end_of_line  = eol;
        res.end_of_frame = eof;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_reg <= WALK_ZERO;
            line_reg  <= WALK_ZERO;
            frame_reg <= FRAME_START;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (accept)
        begin
            pixel_reg <= pixel_next;
            line_reg  <= line_next;
            frame_reg <= frame_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    a_eof_in_eol: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.end_of_frame |-> res.end_of_line)
        else $error("end of frame without end of line");

    a_eol_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res.end_of_line |=> col_reg == '0)
        else $error("column did not wrap after end of line");

    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        accept && restart |-> res.column == '0 && res.row == '0)
        else $error("restart did not start at origin");

endmodule

/* design/rtpg_skid.sv */
module rtpg_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rtpg_pkg::pixel_t  din,
    output logic              in_ready,
    rtpg_pix_if.source        pix
);
    import rtpg_pkg::*;

    pixel_t out_reg, out_next;
    pixel_t skid_reg, skid_next;
    logic   out_valid_reg, out_valid_next;
    logic   skid_valid_reg, skid_valid_next;
    logic   pop;

    assign pop      = out_valid_reg && pix.ready;
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = din;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = din;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign pix.valid        = out_valid_reg;
    assign pix.red          = out_reg.red;
    assign pix.green        = out_reg.green;
    assign pix.blue         = out_reg.blue;
    assign pix.column       = out_reg.column;
    assign pix.row          = out_reg.row;
    assign pix.end_of_line  = out_reg.end_of_line;
    assign pix.end_of_frame = out_reg.end_of_frame;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held while output empty");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pix.ready && push |=> skid_valid_reg)
        else $error("word lost on stall");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pix.ready |=> out_valid_reg && !skid_valid_reg)
        else $error("skid word not moved to output");

endmodule

/* design/rainbow_test_pattern_generator_top.sv */
// rainbow test pattern generator
//
// cmd channel: one word per pixel to produce; restart = 1 returns the
// pattern to its initial frame colour and position 0,0 for this pixel
// pix channel: one word per pixel in raster order with colour, column,
// row and end of line / end of frame marks
// config port: cfg_we writes cfg_data into register cfg_index
// (0 active width, 1 active height, 2 line shift, 3 frame shift);
// the user must write only while the block is idle, which the block itself does not enforce
// output: each pixel is registered into the output buffer when its cmd word is accepted
// throughput: one pixel per cycle while pix.ready stays high; the whole walk step, line and frame
// shifts sit in one combinational stage before the output register
// reset: config returns to 640x480 with shifts of 3, the pattern to its
// first frame, both output words empty
// stall: a two-word output buffer holds results; cmd.ready drops only
// when both words are full and comes back as soon as one is taken
module rainbow_test_pattern_generator_top #(
    parameter int MAX_LINE_PIXELS = rtpg_pkg::MAX_LINE_PIXELS_DEF,
    parameter int MAX_LINES       = rtpg_pkg::MAX_LINES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rtpg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [rtpg_pkg::CFG_W-1:0]   cfg_data,
    rtpg_cmd_if.sink                     cmd,
    rtpg_pix_if.source                   pix
);
    import rtpg_pkg::*;

    cfg_t   cfg;
    pixel_t res;
    logic   accept;
    logic   in_ready;

    assign cmd.ready = in_ready;
    assign accept    = cmd.valid && in_ready;

    rtpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rtpg_gen #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS),
        .MAX_LINES       (MAX_LINES)
    ) u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .restart (cmd.restart),
        .res     (res)
    );

    rtpg_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .din      (res),
        .in_ready (in_ready),
        .pix      (pix)
    );

endmodule
